>>> src/bbc_pkg.sv
// bbc_pkg: shared types, constants and decode functions for the bracket checker
// depends on nothing; used by bracket_balance_checker_core by scoped names

package bbc_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // field widths
    localparam int CHAR_W    = 8;
    localparam int VERDICT_W = 2;
    localparam int TDATA_W   = 8;

    // bracket characters
    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;  // (
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;  // [
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;  // {
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;  // )
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;  // }

    // bracket kind as stored on the stack
    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_BAD      = 2'd1,
        VERDICT_OVERFLOW = 2'd2
    } verdict_t;

    // kind of an opening bracket, or none
    function automatic kind_t open_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        case (c)
            CH_OPEN_ROUND:  k = KIND_ROUND;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    // kind of a closing bracket, or none
    function automatic kind_t close_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        case (c)
            CH_CLOSE_ROUND:  k = KIND_ROUND;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> src/bracket_balance_checker_core.sv
// bracket_balance_checker_core: stream checker for balanced brackets in strings
// depends on bbc_pkg (stack geometry, bracket decode, verdict codes)

// Usage:
//   Input stream s_*: one character per transaction in s_tdata, s_tlast on
//   the final character of a string. Output stream m_*: one verdict per
//   string in m_tdata[1:0] (0 balanced, 1 unbalanced, 2 stack overflow),
//   sent for the transaction that carried s_tlast.
//   Throughput: one character per cycle, back to back, pushes and pops in
//   any mix. The stack lives in a one-port-write, one-port-read memory; the
//   top entry is held in a register and the entry below it is prefetched
//   every cycle, so a pop has its next top ready at the following cycle.
//   Latency: the verdict is valid on m_tvalid the cycle after the last
//   character is taken.
//   Reset (aresetn low, synchronous): stack level and flags clear, output
//   empty; the stack memory needs no clearing pass.
//   Stall: while a verdict waits in the output register, characters that
//   are not last are still taken; a last character waits until the verdict
//   is taken or m_tready is high.

module bracket_balance_checker_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bbc_pkg::TDATA_W-1:0] s_tdata,   // [7:0] char_code
    input  logic                      s_tlast,     // last_char
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bbc_pkg::TDATA_W-1:0] m_tdata    // [1:0] verdict, [7:2] zero
);

    // stack memory and prefetched entry under the top
    bbc_pkg::kind_t stack_mem [bbc_pkg::STACK_DEPTH];
    bbc_pkg::kind_t mem_rdata_reg;

    // control state
    logic [bbc_pkg::LEVEL_W-1:0] level_reg, level_next;
    bbc_pkg::kind_t              top_reg, top_next;
    logic                        failed_reg, failed_next;
    logic                        ovf_reg, ovf_next;
    logic                        m_valid_reg, m_valid_next;
    bbc_pkg::verdict_t           verdict_reg, verdict_next;

    logic                        accept;
    logic                        wr_en;
    logic [bbc_pkg::ADDR_W-1:0]  wr_addr;
    logic [bbc_pkg::ADDR_W-1:0]  rd_addr;
    bbc_pkg::kind_t              okind, ckind;
    logic [bbc_pkg::LEVEL_W-1:0] under_level;

    // handshake
    assign s_tready = !m_valid_reg || m_tready || !s_tlast;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(bbc_pkg::TDATA_W - bbc_pkg::VERDICT_W){1'b0}}, verdict_reg};

    assign okind = bbc_pkg::open_kind(s_tdata[bbc_pkg::CHAR_W-1:0]);
    assign ckind = bbc_pkg::close_kind(s_tdata[bbc_pkg::CHAR_W-1:0]);

    // push/pop and verdict
    always_comb begin
        level_next   = level_reg;
        top_next     = top_reg;
        failed_next  = failed_reg;
        ovf_next     = ovf_reg;
        verdict_next = verdict_reg;
        wr_en        = 1'b0;
        wr_addr      = level_reg[bbc_pkg::ADDR_W-1:0];
        m_valid_next = m_valid_reg && !m_tready;
        if (accept) begin
            if (!failed_reg && !ovf_reg) begin
                if (okind != bbc_pkg::KIND_NONE) begin
                    if (level_reg == bbc_pkg::LEVEL_W'(bbc_pkg::STACK_DEPTH)) begin
                        ovf_next = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        top_next   = okind;
                        level_next = level_reg + bbc_pkg::LEVEL_W'(1);
                    end
                end else if (ckind != bbc_pkg::KIND_NONE) begin
                    if (level_reg == '0) begin
                        failed_next = 1'b1;
                    end else begin
                        level_next = level_reg - bbc_pkg::LEVEL_W'(1);
                        top_next   = mem_rdata_reg;
                        if (top_reg != ckind) begin
                            failed_next = 1'b1;
                        end
                    end
                end
            end
            if (s_tlast) begin
                if (ovf_next) begin
                    verdict_next = bbc_pkg::VERDICT_OVERFLOW;
                end else if (failed_next || level_next != '0) begin
                    verdict_next = bbc_pkg::VERDICT_BAD;
                end else begin
                    verdict_next = bbc_pkg::VERDICT_OK;
                end
                m_valid_next = 1'b1;
                level_next   = '0;
                failed_next  = 1'b0;
                ovf_next     = 1'b0;
            end
        end
    end

    // prefetch the entry under the next top
    assign under_level = level_next - bbc_pkg::LEVEL_W'(2);
    assign rd_addr     = under_level[bbc_pkg::ADDR_W-1:0];

    // stack memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= okind;
        end
        mem_rdata_reg <= stack_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        verdict_reg <= verdict_next;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= '0;
            failed_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            level_reg   <= level_next;
            failed_reg  <= failed_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // checks
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= bbc_pkg::LEVEL_W'(bbc_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(failed_reg && ovf_reg))
        else $error("failure and overflow both set");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=>
            (level_reg == '0 && !failed_reg && !ovf_reg && m_valid_reg))
        else $error("last character did not clear state or raise a verdict");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (level_reg != bbc_pkg::LEVEL_W'(bbc_pkg::STACK_DEPTH)))
        else $error("push onto a full stack");

    a_overflow_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast && ovf_reg) |=>
            (verdict_reg == bbc_pkg::VERDICT_OVERFLOW))
        else $error("overflow not reported");

endmodule
